// ===== design/sv39ptw_pkg.sv =====
// ============================================================================
// sv39ptw_pkg
// Shared widths, codes and word types of the Sv39 page table map and walk
// block and its table memory.
// ============================================================================
package sv39ptw_pkg;

    // Field widths
    localparam int VPN_W    = 27;
    localparam int PPN_W    = 44;
    localparam int CNT_W    = 7;
    localparam int PERM_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 64;

    // Table geometry: 512 entries of one table page, 9 index bits per level
    localparam int IDX_W            = 9;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int PTE_PPN_SHIFT    = 10;

    // Stored entries never use bits above the page number field
    localparam int STORE_W = PTE_PPN_SHIFT + PPN_W;

    // Defaults of the top level parameters
    localparam int DEF_NUM_TABLE_PAGES       = 16;
    localparam int DEF_MAX_PAGES_PER_REQUEST = 64;

    // Reset value of the table base page number
    localparam logic [PPN_W-1:0] BASE_PPN_RESET = 44'd524288;

    // Request codes
    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

    // Input word
    typedef struct packed {
        logic               req_type;
        logic [VPN_W-1:0]   virt_page_number;
        logic [PPN_W-1:0]   phys_page_number;
        logic [CNT_W-1:0]   page_count;
        logic [PERM_W-1:0]  perm_bits;
    } req_word_t;

    // Result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_value;
        logic [VPN_W-1:0]    result_virt_page;
        logic                last_result;
    } rsp_word_t;

endpackage

// ===== design/sv39ptw_table_ram.sv =====
// ============================================================================
// sv39ptw_table_ram
// Table page store: one write port and one read port, read data registered
// and held until the next read.
// ============================================================================
module sv39ptw_table_ram #(
    parameter int ADDR_W = sv39ptw_pkg::IDX_W + 4,
    parameter int DEPTH  = sv39ptw_pkg::DEF_NUM_TABLE_PAGES * sv39ptw_pkg::ENTRIES_PER_PAGE,
    parameter int DATA_W = sv39ptw_pkg::STORE_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sv39_page_table_map_and_walk.sv =====
// ============================================================================
// sv39_page_table_map_and_walk
// Three-level Sv39 page table kept in a local store of table pages, with
// page mapping through a bump allocator and leaf entry lookup.
// ============================================================================
// Usage:
//   The input channel (in_valid / in_stall / in_word) takes one request word:
//   a map of page_count consecutive pages or a lookup of one leaf entry. The
//   output channel (out_valid / out_stall / out_word) returns one word per
//   mapped page, or one word for a lookup or for a walk that stops with an
//   error; last_result marks the final word of a request.
//   Each page walks through the root read, the root evaluation, the middle
//   evaluation and the leaf write (map) or leaf read result (lookup); each
//   level waits for the entry of the level above from the table memory's
//   registered read port. A word is loaded into the output register as its
//   page finishes. A new request is taken once the previous request's last
//   word sits in the output register.
//   A stalled output word holds in the output register; the walk of the next
//   page issues its root read and then waits in the root evaluation until
//   the word is taken.
//   After reset the store is cleared one entry per cycle, NUM_TABLE_PAGES * 512
//   entries (8192 by default), with in_stall high; configuration writes are
//   taken at any time, but are only meant while the block is idle.
// ============================================================================
module sv39_page_table_map_and_walk #(
    parameter int NUM_TABLE_PAGES       = sv39ptw_pkg::DEF_NUM_TABLE_PAGES,
    parameter int MAX_PAGES_PER_REQUEST = sv39ptw_pkg::DEF_MAX_PAGES_PER_REQUEST
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [sv39ptw_pkg::PPN_W-1:0]  cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  sv39ptw_pkg::req_word_t         in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output sv39ptw_pkg::rsp_word_t         out_word
);

    import sv39ptw_pkg::*;

    localparam int PW    = (NUM_TABLE_PAGES > 1) ? $clog2(NUM_TABLE_PAGES) : 1;
    localparam int FW    = $clog2(NUM_TABLE_PAGES + 1);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = NUM_TABLE_PAGES * ENTRIES_PER_PAGE;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD1   = 6'b000100,
        S_EV1   = 6'b001000,
        S_EV2   = 6'b010000,
        S_LEAF  = 6'b100000
    } state_t;

    // Control registers
    state_t            state_reg, state_next;
    logic [PPN_W-1:0]  base_reg, base_next;
    logic [FW-1:0]     free_reg, free_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic              type_reg, type_next;
    logic [VPN_W-1:0]  vpn_reg, vpn_next;
    logic [PPN_W-1:0]  ppn_reg, ppn_next;
    logic [PERM_W-1:0] perm_reg, perm_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [PW-1:0]     p1_reg, p1_next;
    logic [PW-1:0]     p0_reg, p0_next;
    rsp_word_t         out_word_reg, out_word_next;

    // Memory port
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [STORE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [STORE_W-1:0] mem_rdata;

    // Level evaluation
    logic [PPN_W-1:0]   rd_ppn;
    logic [PPN_W-1:0]   rel_page;
    logic               rel_inside;
    logic               pool_empty;
    logic [STORE_W-1:0] alloc_entry;
    logic [STORE_W-1:0] leaf_entry;
    logic               lvl_err;
    logic [STATUS_W-1:0] lvl_status;
    logic               lvl_alloc;
    logic [PW-1:0]      lvl_page;
    logic [CNT_W-1:0]   cnt_clamped;
    logic               out_room;
    logic               emit;

    logic [IDX_W-1:0]   idx_root;
    logic [IDX_W-1:0]   idx_mid;
    logic [IDX_W-1:0]   idx_leaf;

    sv39ptw_table_ram #(
        .ADDR_W (AW),
        .DEPTH  (DEPTH),
        .DATA_W (STORE_W)
    ) u_table_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Split the virtual page number into level indexes
    assign idx_root = vpn_reg[3*IDX_W-1:2*IDX_W];
    assign idx_mid  = vpn_reg[2*IDX_W-1:IDX_W];
    assign idx_leaf = vpn_reg[IDX_W-1:0];

    // Resolve the entry just read against the table region and the allocator
    assign rd_ppn      = mem_rdata[STORE_W-1:PTE_PPN_SHIFT];
    assign rel_page    = rd_ppn - base_reg;
    assign rel_inside  = rel_page < PPN_W'(NUM_TABLE_PAGES);
    assign pool_empty  = free_reg >= FW'(NUM_TABLE_PAGES);
    assign alloc_entry = {base_reg + PPN_W'(free_reg), {(PTE_PPN_SHIFT-1){1'b0}}, 1'b1};
    assign leaf_entry  = {ppn_reg, {(PTE_PPN_SHIFT-PERM_W){1'b0}}, perm_reg};

    always_comb
    begin
        lvl_err    = 1'b0;
        lvl_status = ST_OK;
        lvl_alloc  = 1'b0;
        lvl_page   = '0;
        if (mem_rdata[0])
        begin
            if (rel_inside)
            begin
                lvl_page = rel_page[PW-1:0];
            end
            else
            begin
                lvl_err    = 1'b1;
                lvl_status = ST_OUTSIDE;
            end
        end
        else if (type_reg == REQ_LOOKUP)
        begin
            lvl_err    = 1'b1;
            lvl_status = ST_NOT_FOUND;
        end
        else if (pool_empty)
        begin
            lvl_err    = 1'b1;
            lvl_status = ST_NO_PAGE;
        end
        else
        begin
            lvl_alloc = 1'b1;
            lvl_page  = free_reg[PW-1:0];
        end
    end

    // Clamp the page count into one to the request maximum
    always_comb
    begin
        if (in_word.page_count == '0)
        begin
            cnt_clamped = CNT_W'(1);
        end
        else if (in_word.page_count > CNT_W'(MAX_PAGES_PER_REQUEST))
        begin
            cnt_clamped = CNT_W'(MAX_PAGES_PER_REQUEST);
        end
        else
        begin
            cnt_clamped = in_word.page_count;
        end
    end

    assign out_room = !out_valid_reg || !out_stall;

    // Walk sequencer
    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        free_next     = free_reg;
        clr_next      = clr_reg;
        type_next     = type_reg;
        vpn_next      = vpn_reg;
        ppn_next      = ppn_reg;
        perm_next     = perm_reg;
        rem_next      = rem_reg;
        p1_next       = p1_reg;
        p0_next       = p0_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        emit          = 1'b0;
        out_word_next = out_word_reg;

        if (cfg_write_en)
        begin
            base_next = cfg_write_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    type_next  = in_word.req_type;
                    vpn_next   = in_word.virt_page_number;
                    ppn_next   = in_word.phys_page_number;
                    perm_next  = in_word.perm_bits;
                    rem_next   = cnt_clamped;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {PW'(0), idx_root};
                state_next = S_EV1;
            end
            S_EV1:
            begin
                if (out_room)
                begin
                    if (lvl_err)
                    begin
                        emit          = 1'b1;
                        out_word_next = '{lvl_status, '0, vpn_reg, 1'b1};
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        if (lvl_alloc)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {PW'(0), idx_root};
                            mem_wdata = alloc_entry;
                            free_next = free_reg + FW'(1);
                        end
                        p1_next    = lvl_page;
                        mem_re     = 1'b1;
                        mem_raddr  = {lvl_page, idx_mid};
                        state_next = S_EV2;
                    end
                end
            end
            S_EV2:
            begin
                if (out_room)
                begin
                    if (lvl_err)
                    begin
                        emit          = 1'b1;
                        out_word_next = '{lvl_status, '0, vpn_reg, 1'b1};
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        if (lvl_alloc)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {p1_reg, idx_mid};
                            mem_wdata = alloc_entry;
                            free_next = free_reg + FW'(1);
                        end
                        p0_next = lvl_page;
                        if (type_reg == REQ_LOOKUP)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = {lvl_page, idx_leaf};
                        end
                        state_next = S_LEAF;
                    end
                end
            end
            S_LEAF:
            begin
                if (out_room)
                begin
                    emit = 1'b1;
                    if (type_reg == REQ_LOOKUP)
                    begin
                        out_word_next.status           = mem_rdata[0] ? ST_OK : ST_NOT_FOUND;
                        out_word_next.entry_value      = ENTRY_W'(mem_rdata);
                        out_word_next.result_virt_page = vpn_reg;
                        out_word_next.last_result      = 1'b1;
                        state_next                     = S_IDLE;
                    end
                    else
                    begin
                        // Write the leaf, then advance to the next page or finish
                        mem_we    = 1'b1;
                        mem_waddr = {p0_reg, idx_leaf};
                        mem_wdata = leaf_entry;
                        out_word_next.status           = ST_OK;
                        out_word_next.entry_value      = ENTRY_W'(leaf_entry);
                        out_word_next.result_virt_page = vpn_reg;
                        out_word_next.last_result      = (rem_reg == CNT_W'(1));
                        if (rem_reg == CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rem_next   = rem_reg - CNT_W'(1);
                            vpn_next   = vpn_reg + VPN_W'(1);
                            ppn_next   = ppn_reg + PPN_W'(1);
                            state_next = S_RD1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load the output register on a new word, drop it when taken
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            base_reg      <= BASE_PPN_RESET;
            free_reg      <= FW'(1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            free_reg      <= free_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        perm_reg     <= perm_next;
        rem_reg      <= rem_next;
        p1_reg       <= p1_next;
        p0_reg       <= p0_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A read never meets a write to the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("table read and write hit the same entry");

    // The allocator stays between one and the page count
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != '0) && (free_reg <= FW'(NUM_TABLE_PAGES)))
        else $error("free table page counter out of range");

    // The allocator only advances out of an upper level evaluation
    a_alloc_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != $past(free_reg)) |->
            ($past(state_reg) == S_EV1 || $past(state_reg) == S_EV2))
        else $error("free table page counter moved outside a walk");

    // A new word is posted only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_word == $past(out_word)))
        else $error("stalled result word overwritten");

endmodule
